// ===== rtl/dq_pkg.sv =====
// Shared types for the double-ended queue: request and response items,
// action and status codes, and the controller/datapath command bundle.
// No dependencies.
package dq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned CountOutWidth = 10;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0]       pop_value;
    status_t                  status;
    logic [CountOutWidth-1:0] count_after;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the incoming request item
    logic execute;    // update pointers, write or read the ring
    logic load_read;  // take the ring read data into the response
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_ok;     // the latched request is a pop on a non-empty queue
  } sts_t;

endpackage

// ===== rtl/double_ended_queue_core.sv =====
// Bounded double-ended queue of signed 32-bit values held in a ring RAM.
// A push or an error result is registered in the execute state and shown in
// the output state; a successful pop passes a read state between the two,
// set by the RAM's registered read. One item is in flight at a time: a new
// request is taken only once the last response has been taken.
// Reset (synchronous, rst high) empties the queue; the ring is not cleared.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 512
) (
  input  logic         clk,
  input  logic         rst,
  // Request channel: an item carries an action and a value to push.
  input  logic         req_valid,
  output logic         req_stall,
  input  dq_pkg::req_t req,
  // Response channel: one item per request.
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output dq_pkg::rsp_t rsp
);

  // The controller walks each item through execute, an optional RAM read
  // for pops, and an output state that holds the response until taken.
  // The datapath owns the front index, the item count and the ring, and
  // reports back whether the latched item is a pop that will read the ring.
  dq_pkg::cmd_t cmd;
  dq_pkg::sts_t sts;

  dq_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Pushes at the front move the front index back one slot before writing;
  // pushes at the back write at front plus count. Pops read the front slot
  // or the slot at front plus count minus one, wrapped into the ring.
  dq_datapath #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cmd(cmd),
    .sts(sts)
  );

endmodule

// ===== rtl/dq_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/dq_controller.sv =====
// Sequencing state machine for the double-ended queue.
// Depends on dq_pkg for the command and status bundles.
module dq_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dq_pkg::cmd_t  cmd,
  input  dq_pkg::sts_t  sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (req_valid) state <= S_EXEC;
        S_EXEC: state <= sts.pop_ok ? S_READ : S_OUT;
        S_READ: state <= S_OUT;
        S_OUT:  if (!rsp_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall     = (state != S_IDLE);
  assign rsp_valid     = (state == S_OUT);
  assign cmd.capture   = (state == S_IDLE) && req_valid;
  assign cmd.execute   = (state == S_EXEC);
  assign cmd.load_read = (state == S_READ);

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_EXEC))
    else $error("accepted item did not start execution");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && sts.pop_ok) |=> (state == S_READ))
    else $error("successful pop skipped the ring read");

  a_taken_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall) |=> (state == S_IDLE))
    else $error("response taken but controller not idle");

endmodule

// ===== rtl/dq_datapath.sv =====
// Datapath of the double-ended queue: front index, item count, ring
// addressing with wrap, the ring RAM and the response register.
// Depends on dq_pkg and dq_ram.
module dq_datapath #(
  parameter int unsigned DEPTH = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  dq_pkg::req_t req,
  output dq_pkg::rsp_t rsp,
  input  dq_pkg::cmd_t cmd,
  output dq_pkg::sts_t sts
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned OW = dq_pkg::CountOutWidth;

  dq_pkg::req_t  req_q;
  logic [AW-1:0] front;
  logic [CW-1:0] count;

  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] tail_off;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_pos;
  logic [AW:0]   inc_sum;
  logic [CW-1:0] count_m1;
  logic          full;
  logic          empty;
  logic          is_push;
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rdata;
  dq_pkg::status_t status_next;
  logic [CW+OW-1:0] count_ext;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign is_push  = (req_q.action == dq_pkg::ACT_PUSH_FRONT) ||
                    (req_q.action == dq_pkg::ACT_PUSH_BACK);
  assign count_m1 = count - 1'b1;

  // Both index and offset stay below DEPTH, so one conditional subtract wraps.
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign inc_sum   = {1'b0, front} + (AW + 1)'(1);
  assign front_inc = (inc_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(inc_sum - (AW + 1)'(DEPTH)) : inc_sum[AW-1:0];
  assign tail_off  = (req_q.action == dq_pkg::ACT_PUSH_BACK) ?
                     count[AW-1:0] : count_m1[AW-1:0];
  assign tail_sum  = {1'b0, front} + {1'b0, tail_off};
  assign tail_pos  = (tail_sum >= (AW + 1)'(DEPTH)) ?
                     AW'(tail_sum - (AW + 1)'(DEPTH)) : tail_sum[AW-1:0];

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = dq_pkg::ST_OK;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = front;
    if (is_push && full) begin
      status_next = dq_pkg::ST_FULL;
    end else if (!is_push && empty) begin
      status_next = dq_pkg::ST_EMPTY;
    end else begin
      ram_en = cmd.execute;
      case (req_q.action)
        dq_pkg::ACT_PUSH_FRONT: begin
          ram_we     = 1'b1;
          ram_addr   = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
        dq_pkg::ACT_PUSH_BACK: begin
          ram_we     = 1'b1;
          ram_addr   = tail_pos;
          count_next = count + 1'b1;
        end
        dq_pkg::ACT_POP_FRONT: begin
          ram_addr   = front;
          front_next = front_inc;
          count_next = count_m1;
        end
        default: begin
          ram_addr   = tail_pos;
          count_next = count_m1;
        end
      endcase
    end
  end

  assign count_ext  = {{OW{1'b0}}, count_next};
  assign sts.pop_ok = !is_push && !empty;

  dq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(req_q.push_value),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
    if (cmd.execute) begin
      rsp.pop_value   <= '0;
      rsp.status      <= status_next;
      rsp.count_after <= count_ext[OW-1:0];
    end
    if (cmd.load_read) begin
      rsp.pop_value <= ram_rdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count exceeds ring depth");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && ((is_push && full) || (!is_push && empty)))
    |=> ($stable(front) && $stable(count)))
    else $error("rejected operation changed queue state");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && is_push && !full) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the count by one");

endmodule

// ===== tb/tb_double_ended_queue_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_core: directed rows, then random traffic
// that fills the ring, pushes on full, then mixes. Depends on dq_pkg and the core RTL.
module tb_double_ended_queue_core;

  localparam int unsigned DEPTH = 512;
  localparam int unsigned CountW = dq_pkg::CountOutWidth;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  dq_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  dq_pkg::rsp_t rsp;

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 12 ns clock period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One row of the directed table. When has_want is set, the response is written
  // out in the row and is used in place of the shadow queue's prediction.
  typedef struct {
    dq_pkg::action_t    action;
    logic signed [31:0] value;
    bit                 has_want;
    dq_pkg::rsp_t       want;
  } plan_row_t;

  plan_row_t plan[$];

  // Shadow copy of the queue: the ring, its front position and its fill level.
  logic signed [31:0] shadow_ring [DEPTH];
  int unsigned        shadow_front;
  int unsigned        shadow_count;

  // Responses still owed by the core, oldest first.
  dq_pkg::rsp_t due_responses[$];

  // Written-out answer for the item currently offered by the sender.
  bit           row_has_want;
  dq_pkg::rsp_t row_want;

  // When calm is set, neither the sender nor the receiver inserts idle cycles.
  bit calm;

  int fault_count;
  int pushes_ok, pops_ok, empty_hits, full_hits, peak_fill, items_sent;

  // Applies one request to the shadow queue and returns the response that the
  // core owes for it.
  function automatic dq_pkg::rsp_t deque_apply(dq_pkg::req_t r);
    dq_pkg::rsp_t o;
    int unsigned  slot;
    o.pop_value = '0;
    o.status    = dq_pkg::ST_OK;
    case (r.action) inside
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          o.status = dq_pkg::ST_FULL;
        end else if (r.action == dq_pkg::ACT_PUSH_FRONT) begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = r.push_value;
          shadow_count++;
        end else begin
          slot = (shadow_front + shadow_count) % DEPTH;
          shadow_ring[slot] = r.push_value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          o.status = dq_pkg::ST_EMPTY;
        end else if (r.action == dq_pkg::ACT_POP_FRONT) begin
          // Only the front entry leaves; the back stays where it is.
          o.pop_value = shadow_ring[shadow_front];
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end else begin
          slot = (shadow_front + shadow_count - 1) % DEPTH;
          o.pop_value = shadow_ring[slot];
          shadow_count--;
        end
      end
    endcase
    o.count_after = CountW'(shadow_count);
    return o;
  endfunction

  function automatic void note_fault(string msg);
    if (fault_count < 10) $display("MISMATCH at %0t ns: %s", $time, msg);
    fault_count++;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random action, a push with the given chance in percent, either end alike.
  function automatic dq_pkg::action_t pick_action(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT;
    return $urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT;
  endfunction

  function automatic void plan_add(dq_pkg::action_t a, logic signed [31:0] v,
                                   bit has_want, logic signed [31:0] pv,
                                   dq_pkg::status_t st, int unsigned cnt);
    plan_row_t row;
    row.action            = a;
    row.value             = v;
    row.has_want          = has_want;
    row.want.pop_value    = pv;
    row.want.status       = st;
    row.want.count_after  = CountW'(cnt);
    plan.push_back(row);
  endfunction

  // Offers one item, called at a falling edge. It returns at the falling edge
  // after the item was taken, with valid still high so that a following item
  // can go out without a gap.
  task automatic send_request(input dq_pkg::action_t a, input logic signed [31:0] v,
                              input bit has_want, input dq_pkg::rsp_t want);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid        <= 1'b1;
    req.action       <= a;
    req.push_value   <= v;
    row_has_want     <= has_want;
    row_want         <= want;
    do @(posedge clk); while (req_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int push_pct);
    dq_pkg::rsp_t none;
    none = '0;
    send_request(pick_action(push_pct), $urandom(), 1'b0, none);
  endtask

  // Holds the sender back until the core has answered everything taken so far.
  task automatic wait_for_quiet();
    req_valid <= 1'b0;
    @(negedge clk);
    while (due_responses.size() != 0) @(negedge clk);
  endtask

  // Receiver side: random stall bursts, changed only at falling edges.
  int hold_left;
  always @(negedge clk) begin : rsp_side
    int span;
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rsp_stall) begin
      rsp_stall <= 1'b0;
      hold_left <= $urandom_range(0, 11);
    end else begin
      span = idle_span();
      if (span > 0) begin
        rsp_stall <= 1'b1;
        hold_left <= span - 1;
      end else begin
        hold_left <= $urandom_range(0, 5);
      end
    end
  end

  // Every item the core takes is run through the shadow queue at the same edge.
  always @(posedge clk) begin : req_track
    dq_pkg::rsp_t got;
    if (!rst && req_valid && !req_stall) begin
      got = deque_apply(req);
      case (got.status)
        dq_pkg::ST_EMPTY: empty_hits++;
        dq_pkg::ST_FULL:  full_hits++;
        default: begin
          if (req.action == dq_pkg::ACT_PUSH_FRONT || req.action == dq_pkg::ACT_PUSH_BACK)
            pushes_ok++;
          else
            pops_ok++;
        end
      endcase
      if (shadow_count > peak_fill) peak_fill = shadow_count;
      due_responses.push_back(row_has_want ? row_want : got);
    end
  end

  // Every response the receiver takes is compared with the oldest one owed.
  always @(posedge clk) begin : rsp_check
    dq_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_responses.size() == 0) begin
        note_fault($sformatf("response with nothing owed: value %0d status %0d count %0d",
                             rsp.pop_value, rsp.status, rsp.count_after));
      end else begin
        want = due_responses.pop_front();
        if (rsp.pop_value !== want.pop_value || rsp.status !== want.status ||
            rsp.count_after !== want.count_after)
          note_fault($sformatf("want value %0d status %0d count %0d, got %0d %0d %0d",
                               want.pop_value, want.status, want.count_after,
                               rsp.pop_value, rsp.status, rsp.count_after));
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin
    #(6_000_000);
    $display("Run timed out with %0d responses still owed.", due_responses.size());
    $display("** double_ended_queue_core: FAILED **");
    $finish;
  end

  initial begin : main
    int wait_n;
    dq_pkg::rsp_t none;
    none         = '0;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_stall    = 1'b0;
    calm         = 1'b0;
    row_has_want = 1'b0;
    row_want     = '0;
    shadow_front = 0;
    shadow_count = 0;
    fault_count  = 0;
    pushes_ok    = 0;
    pops_ok      = 0;
    empty_hits   = 0;
    full_hits    = 0;
    peak_fill    = 0;
    items_sent   = 0;

    // Directed table. Rows with a written-out answer are the ones readable at a
    // glance: errors on an empty queue and the fill level after each push.
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         1, 32'sd0, dq_pkg::ST_EMPTY, 0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         1, 32'sd0, dq_pkg::ST_EMPTY, 0);
    plan_add(dq_pkg::ACT_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 32'sd0, dq_pkg::ST_OK,    1);
    plan_add(dq_pkg::ACT_PUSH_BACK,  32'sh8000_0000, 1, 32'sd0, dq_pkg::ST_OK,    2);
    plan_add(dq_pkg::ACT_PUSH_FRONT, 32'sd0,         1, 32'sd0, dq_pkg::ST_OK,    3);
    plan_add(dq_pkg::ACT_PUSH_BACK,  -32'sd1,        1, 32'sd0, dq_pkg::ST_OK,    4);
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         1, 32'sd0, dq_pkg::ST_EMPTY, 0);
    plan_add(dq_pkg::ACT_PUSH_BACK,  32'sh5555_5555, 1, 32'sd0, dq_pkg::ST_OK,    1);
    plan_add(dq_pkg::ACT_PUSH_BACK,  32'shAAAA_AAAA, 1, 32'sd0, dq_pkg::ST_OK,    2);
    // A front pop must leave the back entry in place.
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         1, 32'sd0, dq_pkg::ST_EMPTY, 0);
    plan_add(dq_pkg::ACT_PUSH_FRONT, 32'sh1234_5678, 1, 32'sd0, dq_pkg::ST_OK,    1);
    plan_add(dq_pkg::ACT_POP_FRONT,  32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_PUSH_BACK,  32'shDEAD_BEEF, 1, 32'sd0, dq_pkg::ST_OK,    1);
    plan_add(dq_pkg::ACT_PUSH_FRONT, 32'sh0F0F_0F0F, 1, 32'sd0, dq_pkg::ST_OK,    2);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);
    plan_add(dq_pkg::ACT_POP_BACK,   32'sd0,         0, 32'sd0, dq_pkg::ST_OK,    0);

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i])
      send_request(plan[i].action, plan[i].value, plan[i].has_want, plan[i].want);

    // Let the core run dry once before the random traffic starts.
    wait_for_quiet();

    // Short mixed stretch around an almost empty queue.
    repeat (40) send_random(50);

    // Fill the ring with mostly pushes. The first part runs with no idle
    // cycles at all so that back-to-back items are covered.
    while (shadow_count < DEPTH) begin
      calm <= (shadow_count < 120);
      send_random(95);
    end
    calm <= 1'b0;

    // Pushes on a full queue at both ends, then traffic at the full edge.
    send_request(dq_pkg::ACT_PUSH_FRONT, $urandom(), 1'b0, none);
    send_request(dq_pkg::ACT_PUSH_BACK, $urandom(), 1'b0, none);
    repeat (12) send_random(60);

    wait_for_quiet();

    repeat (50) send_random(45);

    // All items are in; collect the remaining responses, with a bound.
    req_valid <= 1'b0;
    wait_n = 0;
    while (due_responses.size() != 0 && wait_n < 20000) begin
      @(negedge clk);
      wait_n++;
    end
    repeat (8) @(negedge clk);
    while (due_responses.size() != 0) begin
      void'(due_responses.pop_front());
      note_fault("response owed but never delivered");
    end

    $display("Sent %0d items: %0d pushes, %0d pops, %0d empty and %0d full errors.",
             items_sent, pushes_ok, pops_ok, empty_hits, full_hits);
    $display("Peak fill %0d of %0d entries, %0d faults.", peak_fill, DEPTH, fault_count);
    if (fault_count == 0) begin
      $display("** double_ended_queue_core: PASSED **");
    end else begin
      $display("** double_ended_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
